// ===== rtl/adjm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix graph store package
// Shared sizes, codes, controller/datapath interface types and row helpers.
// ----------------------------------------------------------------------------
package adjm_pkg;

  localparam int unsigned MAX_VERTICES = 16;

  // Sizes that follow from the vertex capacity
  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned ROW_W = MAX_VERTICES;

  // Fixed field widths at the block boundary
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned IN_IDX_W   = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_O_W  = 7;
  localparam int unsigned ROW_IDX_W  = 6;
  localparam int unsigned ROW_BITS_W = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_VERTEX    = 3'd0,
    ACT_REMOVE_VERTEX = 3'd1,
    ACT_ADD_EDGE      = 3'd2,
    ACT_REMOVE_EDGE   = 3'd3,
    ACT_DUMP          = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ADD,
    S_EDGE_A,
    S_EDGE_B,
    S_EDGE_C,
    S_WALK,
    S_DRAIN,
    S_RESP_OK,
    S_RESP_BAD,
    S_RESP_FULL
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    latch;      // capture the input item
    logic    add_wr;     // append a vertex, bump the count
    logic    edge_rd_a;  // read row of first endpoint
    logic    edge_wr_a;  // write first row, read second
    logic    edge_wr_b;  // write second row
    logic    walk_clr;   // rewind the row walk
    logic    walk_rd;    // read next row of the walk
    logic    cnt_dec;    // drop one vertex from the count
    logic    emit_resp;  // send a single non-row result
    status_e resp_status;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                full;
    logic                vtx_bad;
    logic                edge_bad;
    logic                empty;
    logic                single;
    logic                rd_last;
  } dp_sts_t;

  // Delete bit pos from a row, moving the higher bits down by one
  function automatic logic [ROW_W-1:0] drop_bit(logic [ROW_W-1:0] row,
                                                logic [IDX_W-1:0] pos);
    logic [ROW_W-1:0] low_mask;
    low_mask = (ROW_W'(1) << pos) - ROW_W'(1);
    return (row & low_mask) | ((row >> 1) & ~low_mask);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/adjm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module adjm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/adjm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graph store controller
// Sequences each item through check, memory access, row walk and response.
// ----------------------------------------------------------------------------
module adjm_ctrl
  import adjm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire dp_sts_t sts_i,
  output      dp_cmd_t cmd_o,
  output      logic    busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      S_IDLE: begin
        if (start_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        case (sts_i.act) inside
          ACT_ADD_VERTEX: begin
            state_d = sts_i.full ? S_RESP_FULL : S_ADD;
          end
          ACT_REMOVE_VERTEX: begin
            if (sts_i.vtx_bad)     state_d = S_RESP_BAD;
            else if (sts_i.single) state_d = S_DRAIN;
            else                   state_d = S_WALK;
          end
          ACT_ADD_EDGE, ACT_REMOVE_EDGE: begin
            state_d = sts_i.edge_bad ? S_RESP_BAD : S_EDGE_A;
          end
          ACT_DUMP: begin
            state_d = sts_i.empty ? S_RESP_OK : S_WALK;
          end
          default: state_d = S_RESP_BAD;
        endcase
      end
      S_ADD:    state_d = S_RESP_OK;
      S_EDGE_A: state_d = S_EDGE_B;
      S_EDGE_B: state_d = S_EDGE_C;
      S_EDGE_C: state_d = S_RESP_OK;
      S_WALK: begin
        if (sts_i.rd_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = (sts_i.act == ACT_REMOVE_VERTEX) ? S_RESP_OK : S_IDLE;
      end
      S_RESP_OK, S_RESP_BAD, S_RESP_FULL: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.resp_status = ST_OK;
    busy_o            = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.latch = start_i;
      end
      S_CHECK:  cmd_o.walk_clr  = 1'b1;
      S_ADD:    cmd_o.add_wr    = 1'b1;
      S_EDGE_A: cmd_o.edge_rd_a = 1'b1;
      S_EDGE_B: cmd_o.edge_wr_a = 1'b1;
      S_EDGE_C: cmd_o.edge_wr_b = 1'b1;
      S_WALK:   cmd_o.walk_rd   = 1'b1;
      S_DRAIN:  cmd_o.cnt_dec   = (sts_i.act == ACT_REMOVE_VERTEX);
      S_RESP_OK: begin
        cmd_o.emit_resp   = 1'b1;
        cmd_o.resp_status = ST_OK;
      end
      S_RESP_BAD: begin
        cmd_o.emit_resp   = 1'b1;
        cmd_o.resp_status = ST_BAD_INDEX;
      end
      S_RESP_FULL: begin
        cmd_o.emit_resp   = 1'b1;
        cmd_o.resp_status = ST_FULL;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/adjm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graph store datapath
// Value and adjacency memories, vertex count, row walk and result registers.
// ----------------------------------------------------------------------------
module adjm_dpath
  import adjm_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dp_cmd_t                     cmd_i,
  output      dp_sts_t                     sts_o,
  input  wire logic [ACTION_W-1:0]         action_i,
  input  wire logic signed [VALUE_W-1:0]   vertex_value_i,
  input  wire logic [IN_IDX_W-1:0]         first_index_i,
  input  wire logic [IN_IDX_W-1:0]         second_index_i,
  output      logic                        done_o,
  output      logic [STATUS_W-1:0]         status_o,
  output      logic [COUNT_O_W-1:0]        vertex_count_o,
  output      logic                        row_valid_o,
  output      logic [ROW_IDX_W-1:0]        row_index_o,
  output      logic signed [VALUE_W-1:0]   row_value_o,
  output      logic [ROW_BITS_W-1:0]       row_bits_o,
  output      logic                        last_o
);

  // Latched item
  logic [ACTION_W-1:0] act_q;
  logic [VALUE_W-1:0]  value_q;
  logic [IN_IDX_W-1:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q   <= action_i;
      value_q <= vertex_value_i;
      a_q     <= first_index_i;
      b_q     <= second_index_i;
    end
  end

  logic [IDX_W-1:0] a_idx, b_idx;
  assign a_idx = a_q[IDX_W-1:0];
  assign b_idx = b_q[IDX_W-1:0];

  // Vertex count
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (cmd_i.add_wr)       count_d = count_q + CNT_W'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  logic [IDX_W-1:0] n_idx;
  assign n_idx = count_q[IDX_W-1:0];

  // Checks against the current count
  logic [COUNT_O_W-1:0] a_ext, b_ext, n_ext;
  assign a_ext = COUNT_O_W'(a_q);
  assign b_ext = COUNT_O_W'(b_q);
  assign n_ext = COUNT_O_W'(count_q);

  // Row walk: read stage and write/emit stage
  logic [IDX_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [IDX_W-1:0] wr_cnt_q;
  logic             pipe_v_q;
  logic [CNT_W-1:0] walk_lim;
  logic             is_dump, is_remove, is_add_edge;

  assign is_dump     = (act_q == ACT_DUMP);
  assign is_remove   = (act_q == ACT_REMOVE_VERTEX);
  assign is_add_edge = (act_q == ACT_ADD_EDGE);
  assign walk_lim    = is_dump ? count_q : (count_q - CNT_W'(1));

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (cmd_i.walk_clr)     rd_cnt_d = '0;
    else if (cmd_i.walk_rd) rd_cnt_d = rd_cnt_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      pipe_v_q <= 1'b0;
    end else begin
      rd_cnt_q <= rd_cnt_d;
      pipe_v_q <= cmd_i.walk_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_rd) begin
      wr_cnt_q <= rd_cnt_q;
    end
  end

  assign sts_o.act      = act_q;
  assign sts_o.full     = (count_q == CNT_W'(MAX_VERTICES));
  assign sts_o.vtx_bad  = (a_ext >= n_ext);
  assign sts_o.edge_bad = (a_ext >= n_ext) || (b_ext >= n_ext) || (a_q == b_q);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.single   = (count_q == CNT_W'(1));
  assign sts_o.rd_last  = (CNT_W'(rd_cnt_q) == (walk_lim - CNT_W'(1)));

  // Memories
  logic                 val_we, row_we, mem_re;
  logic [IDX_W-1:0]     val_waddr, row_waddr, raddr;
  logic [VALUE_W-1:0]   val_wdata, val_rdata;
  logic [ROW_W-1:0]     row_wdata, row_rdata;
  logic [IDX_W-1:0]     walk_src;
  logic                 pipe_wr;
  logic [ROW_W-1:0]     bit_a, bit_b;

  // Removal copies row k+1 down to row k from the removed index on
  assign walk_src = (rd_cnt_q < a_idx) ? rd_cnt_q : (rd_cnt_q + IDX_W'(1));
  assign pipe_wr  = pipe_v_q && is_remove;
  assign bit_a    = ROW_W'(1) << a_idx;
  assign bit_b    = ROW_W'(1) << b_idx;

  always_comb begin
    mem_re    = 1'b0;
    raddr     = rd_cnt_q;
    val_we    = 1'b0;
    val_waddr = n_idx;
    val_wdata = value_q;
    row_we    = 1'b0;
    row_waddr = n_idx;
    row_wdata = '0;
    if (cmd_i.edge_rd_a) begin
      mem_re = 1'b1;
      raddr  = a_idx;
    end
    if (cmd_i.edge_wr_a) begin
      mem_re = 1'b1;
      raddr  = b_idx;
    end
    if (cmd_i.walk_rd) begin
      mem_re = 1'b1;
      raddr  = is_remove ? walk_src : rd_cnt_q;
    end
    if (cmd_i.add_wr) begin
      val_we = 1'b1;
      row_we = 1'b1;
    end
    if (cmd_i.edge_wr_a) begin
      row_we    = 1'b1;
      row_waddr = a_idx;
      row_wdata = is_add_edge ? (row_rdata | bit_b) : (row_rdata & ~bit_b);
    end
    if (cmd_i.edge_wr_b) begin
      row_we    = 1'b1;
      row_waddr = b_idx;
      row_wdata = is_add_edge ? (row_rdata | bit_a) : (row_rdata & ~bit_a);
    end
    if (pipe_wr) begin
      val_we    = 1'b1;
      val_waddr = wr_cnt_q;
      val_wdata = val_rdata;
      row_we    = 1'b1;
      row_waddr = wr_cnt_q;
      row_wdata = drop_bit(row_rdata, a_idx);
    end
  end

  adjm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_VERTICES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  adjm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_VERTICES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (row_rdata)
  );

  // Result registers
  logic                  row_emit, wr_last;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [COUNT_O_W-1:0]  out_count_q;
  logic                  out_row_valid_q;
  logic [ROW_IDX_W-1:0]  out_row_index_q;
  logic [VALUE_W-1:0]    out_row_value_q;
  logic [ROW_BITS_W-1:0] out_row_bits_q;
  logic                  out_last_q;

  assign row_emit = pipe_v_q && is_dump;
  assign wr_last  = (CNT_W'(wr_cnt_q) == (count_q - CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_resp || row_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_emit) begin
      out_status_q    <= ST_OK;
      out_count_q     <= n_ext;
      out_row_valid_q <= 1'b1;
      out_row_index_q <= ROW_IDX_W'(wr_cnt_q);
      out_row_value_q <= val_rdata;
      out_row_bits_q  <= ROW_BITS_W'(row_rdata);
      out_last_q      <= wr_last;
    end else if (cmd_i.emit_resp) begin
      out_status_q    <= cmd_i.resp_status;
      out_count_q     <= n_ext;
      out_row_valid_q <= 1'b0;
      out_row_index_q <= '0;
      out_row_value_q <= '0;
      out_row_bits_q  <= '0;
      out_last_q      <= 1'b1;
    end
  end

  assign done_o         = out_valid_q;
  assign status_o       = out_status_q;
  assign vertex_count_o = out_count_q;
  assign row_valid_o    = out_row_valid_q;
  assign row_index_o    = out_row_index_q;
  assign row_value_o    = out_row_value_q;
  assign row_bits_o     = out_row_bits_q;
  assign last_o         = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/adjacency_matrix_graph_store_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix graph store
// Undirected graph of up to MAX_VERTICES vertices: value list plus bit matrix.
// ----------------------------------------------------------------------------
// Issue an item by raising start while busy is low; the item is taken at that
// edge and busy stays high until the block can take the next one. Results come
// out on done_o, each for exactly one cycle, and the receiver cannot stall
// them, so sample every cycle in which done_o is high. Every item gives one
// result with last_o set, except a dump of a non-empty graph, which gives one
// result per stored row (row_valid_o high) with last_o on the final row.
// Item steps, in order: a rejected item and a dump of an empty graph go from
// the check straight to the response; an add vertex writes its entry, then
// responds; an edge update reads the first row, writes it while reading the
// second, then writes the second (read-modify-write of both symmetric rows
// through the single read port). Removing one of several vertices and dumping a
// non-empty graph use the row walk, moving one row per cycle. A new item may
// be issued while busy is low, even while the final result is on the outputs.
// The memories hold no reset value; every entry below the vertex count is
// written by an add before it is read.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_unit
  import adjm_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic [ACTION_W-1:0]       action_i,
  input  wire logic signed [VALUE_W-1:0] vertex_value_i,
  input  wire logic [IN_IDX_W-1:0]       first_index_i,
  input  wire logic [IN_IDX_W-1:0]       second_index_i,
  output      logic                      done_o,
  output      logic [STATUS_W-1:0]       status_o,
  output      logic [COUNT_O_W-1:0]      vertex_count_o,
  output      logic                      row_valid_o,
  output      logic [ROW_IDX_W-1:0]      row_index_o,
  output      logic signed [VALUE_W-1:0] row_value_o,
  output      logic [ROW_BITS_W-1:0]     row_bits_o,
  output      logic                      last_o
);

  // Command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer: check the item, then drive memory accesses and the row walk
  adjm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (dp_sts),
    .cmd_o   (dp_cmd),
    .busy_o  (busy)
  );

  // Datapath: memories, vertex count, walk counters and result registers
  adjm_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .action_i       (action_i),
    .vertex_value_i (vertex_value_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .vertex_count_o (vertex_count_o),
    .row_valid_o    (row_valid_o),
    .row_index_o    (row_index_o),
    .row_value_o    (row_value_o),
    .row_bits_o     (row_bits_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
